// File: src/console_line_editor_unit_macros.svh
// assertion macros for the console line editor checker
// used by the checker file only, expects clk and rst in scope
`ifndef CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH
`define CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH

// same-cycle implication
`define CLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cle_pkg.sv
// shared types, key codes and action codes for the console line editor
// no dependencies
package cle_pkg;

  localparam int LINE_MAX    = 32;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = $clog2(LINE_MAX);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(32);

  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_CTRLX = 8'h18;
  localparam logic [7:0] KEY_CTRLC = 8'h03;
  localparam logic [7:0] KEY_PRINT = 8'h20;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ECHO    = 3'd1;
  localparam logic [2:0] ACT_ERASE   = 3'd2;
  localparam logic [2:0] ACT_NL      = 3'd3;
  localparam logic [2:0] ACT_CANCEL  = 3'd4;
  localparam logic [2:0] ACT_ABANDON = 3'd5;
  localparam logic [2:0] ACT_BYTE    = 3'd6;

  localparam logic [1:0] STAT_BUSY   = 2'd0;
  localparam logic [1:0] STAT_NORMAL = 2'd1;
  localparam logic [1:0] STAT_ESC    = 2'd2;
  localparam logic [1:0] STAT_CANCEL = 2'd3;

  // one classified key as it travels from front to back
  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       ch;
    logic [CNT_W-1:0] cnt;   // erase count, or line length on carriage return
  } cmd_t;

  function automatic logic [1:0] act_status(input logic [2:0] action);
    logic [1:0] s;
    case (action)
      ACT_NL, ACT_BYTE: s = STAT_NORMAL;
      ACT_CANCEL:       s = STAT_ESC;
      ACT_ABANDON:      s = STAT_CANCEL;
      default:          s = STAT_BUSY;
    endcase
    return s;
  endfunction

endpackage

// File: src/cle_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/cle_front.sv
// key intake: length limit register, char count, classification, store writes
// depends on cle_pkg
module cle_front import cle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       key_byte,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [5:0]       cfg_data,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd,
  output logic             ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]       ram_wdata,
  input  logic             line_done
);

  logic [CNT_W-1:0] length_limit;
  logic [CNT_W-1:0] char_count;
  logic [CNT_W-1:0] char_count_next;
  logic [CNT_W-1:0] eff_limit;
  logic             cr_pending;
  logic             accept;
  logic             store_key;
  cmd_t             cmd;

  assign cfg_ready = 1'b1;
  // hold off new keys while the queue is full or a finished line is not yet read out of the store
  assign in_stall  = q_full || cr_pending;
  assign accept    = in_valid && !in_stall;
  assign eff_limit = (length_limit < CNT_W'(LINE_MAX)) ? length_limit : CNT_W'(LINE_MAX);

  always_comb begin
    cmd             = '{action: ACT_NONE, ch: 8'h00, cnt: '0};
    char_count_next = char_count;
    store_key       = 1'b0;
    case (key_byte)
      KEY_CR: begin
        cmd.action      = ACT_NL;
        cmd.cnt         = char_count;
        char_count_next = '0;
      end
      KEY_BS: begin
        if (char_count != '0) begin
          cmd.action      = ACT_ERASE;
          cmd.cnt         = CNT_W'(1);
          char_count_next = char_count - CNT_W'(1);
        end
      end
      KEY_ESC: begin
        cmd.action      = ACT_CANCEL;
        cmd.cnt         = char_count;
        char_count_next = '0;
      end
      KEY_CTRLX: begin
        if (char_count != '0) begin
          cmd.action = ACT_ERASE;
          cmd.cnt    = char_count;
        end
        char_count_next = '0;
      end
      KEY_CTRLC: begin
        cmd.action      = ACT_ABANDON;
        char_count_next = '0;
      end
      default: begin
        if (key_byte >= KEY_PRINT && char_count < eff_limit) begin
          cmd.action      = ACT_ECHO;
          cmd.ch          = key_byte;
          char_count_next = char_count + CNT_W'(1);
          store_key       = 1'b1;
        end
      end
    endcase
  end

  assign push      = accept;
  assign push_cmd  = cmd;
  assign ram_we    = accept && store_key;
  assign ram_waddr = char_count[ADDR_W-1:0];
  assign ram_wdata = key_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
      char_count   <= '0;
      cr_pending   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        length_limit <= cfg_data;
      end
      if (accept) begin
        char_count <= char_count_next;
      end
      if (accept && key_byte == KEY_CR) begin
        cr_pending <= 1'b1;
      end else if (line_done) begin
        cr_pending <= 1'b0;
      end
    end
  end

endmodule

// File: src/cle_queue.sv
// short command queue between key intake and result generation
// depends on cle_pkg
module cle_queue import cle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// File: src/cle_back.sv
// result generation: one result per command, line readout on carriage return
// depends on cle_pkg
module cle_back import cle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              pop,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              line_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        action,
  output logic [7:0]        out_char,
  output logic [CNT_W-1:0]  erase_count,
  output logic [CNT_W-1:0]  line_length,
  output logic [1:0]        status,
  output logic              last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] len_next;
  logic             slot_free;
  logic             load;
  logic [2:0]       action_next;
  logic [7:0]       out_char_next;
  logic [CNT_W-1:0] erase_count_next;
  logic [CNT_W-1:0] line_length_next;
  logic [1:0]       status_next;
  logic             last_next;

  assign slot_free = !out_valid || !out_stall;
  assign idx_inc   = idx + CNT_W'(1);
  assign ram_raddr = idx[ADDR_W-1:0];

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    len_next         = len;
    pop              = 1'b0;
    ram_re           = 1'b0;
    load             = 1'b0;
    line_done        = 1'b0;
    action_next      = action;
    out_char_next    = out_char;
    erase_count_next = erase_count;
    line_length_next = line_length;
    status_next      = status;
    last_next        = last;
    case (state)
      ST_IDLE: begin
        if (!q_empty && slot_free) begin
          pop              = 1'b1;
          load             = 1'b1;
          action_next      = q_cmd.action;
          out_char_next    = q_cmd.ch;
          erase_count_next = (q_cmd.action == ACT_ERASE || q_cmd.action == ACT_CANCEL) ?
                             q_cmd.cnt : '0;
          line_length_next = (q_cmd.action == ACT_NL) ? q_cmd.cnt : '0;
          status_next      = act_status(q_cmd.action);
          last_next        = !(q_cmd.action == ACT_NL && q_cmd.cnt != '0);
          if (q_cmd.action == ACT_NL) begin
            if (q_cmd.cnt == '0) begin
              line_done = 1'b1;
            end else begin
              state_next = ST_ADDR;
              idx_next   = '0;
              len_next   = q_cmd.cnt;
            end
          end
        end
      end
      ST_ADDR: begin
        ram_re     = 1'b1;
        state_next = ST_DATA;
      end
      ST_DATA: begin
        // read data stays put until the next read, so waiting on a stall is safe
        if (slot_free) begin
          load             = 1'b1;
          action_next      = ACT_BYTE;
          out_char_next    = ram_rdata;
          erase_count_next = '0;
          line_length_next = len;
          status_next      = STAT_NORMAL;
          last_next        = (idx_inc == len);
          if (idx_inc == len) begin
            line_done  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = ST_ADDR;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    len         <= len_next;
    action      <= action_next;
    out_char    <= out_char_next;
    erase_count <= erase_count_next;
    line_length <= line_length_next;
    status      <= status_next;
    last        <= last_next;
  end

endmodule

// File: src/console_line_editor_unit.sv
// top level of the console line editor: front, queue, back and line store
// depends on cle_pkg, cle_front, cle_queue, cle_back, cle_ram
//
// Usage:
//   Input channel: key_byte with in_valid/in_stall, one received key per transfer.
//   Output channel: action, out_char, erase_count, line_length, status, last with
//   out_valid/out_stall. Every key gives one result with last set, except a
//   carriage return, which gives a newline result followed by one line byte per
//   stored character, last set on the final one.
//   Config channel: cfg_data with cfg_valid/cfg_ready writes length_limit;
//   cfg_ready is always high. Write it only while the block is idle.
//   A key's command is registered in the queue, then loaded into the output register.
//   Throughput: one key per cycle while the four-entry command queue has room;
//   line readout does a ram read then an output load for each stored byte,
//   and new keys are held off until the line's last result is loaded.
//   A stall on the output holds the result register; the queue keeps taking
//   keys until it fills, then in_stall rises.
//   Reset clears the count, the queue and the output valid; length_limit
//   returns to 32. The line store is not cleared and needs no sweep.
module console_line_editor_unit import cle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] action,
  output logic [7:0] out_char,
  output logic [5:0] erase_count,
  output logic [5:0] line_length,
  output logic [1:0] status,
  output logic       last
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              pop_cmd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              line_done;

  cle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_byte  (key_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .line_done (line_done)
  );

  cle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (pop_cmd),
    .pop         (pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .line_done   (line_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .out_char    (out_char),
    .erase_count (erase_count),
    .line_length (line_length),
    .status      (status),
    .last        (last)
  );

endmodule

// File: src/cle_checker.sv
// port-level checks for the console line editor, bound to the top level
// depends on cle_pkg and console_line_editor_unit_macros.svh
`include "console_line_editor_unit_macros.svh"

module cle_checker import cle_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] action,
  input logic [7:0] out_char,
  input logic [5:0] erase_count,
  input logic [5:0] line_length,
  input logic [1:0] status,
  input logic       last
);

  logic        stalled;
  logic [11:0] shown;
  logic        line_act;
  logic        byte_ok;
  logic        echo_ok;

  assign stalled  = out_valid && out_stall;
  assign shown    = {action, out_char, last};
  assign line_act = (action == ACT_NL) || (action == ACT_BYTE);
  assign byte_ok  = (line_length != 6'd0) && (status == STAT_NORMAL) && (erase_count == 6'd0);
  assign echo_ok  = (out_char >= KEY_PRINT) && (erase_count == 6'd0) &&
                    (line_length == 6'd0) && (status == STAT_BUSY) && last;

  // stalled result stays put: valid, action, char and last are held
  `CLE_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(shown), "stalled result changed")

  // only a line readout spans several results
  `CLE_ASSERT_IMP(a_multi_only_line, out_valid && !last, line_act, "non-final result not a line")

  // a line byte always belongs to a non-empty finished line
  `CLE_ASSERT_IMP(a_byte_line, out_valid && action == ACT_BYTE, byte_ok, "bad line byte result")

  // echoed keys are printable and carry no erase or length
  `CLE_ASSERT_IMP(a_echo_clean, out_valid && action == ACT_ECHO, echo_ok, "malformed echo result")

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (.*);
